// ===== hw/rtl/prom_pkg.sv =====
package prom_pkg;

  localparam int MaxRead    = 256;
  localparam int PadLen     = 8;
  localparam int MinOverlap = 15;
  localparam int MaxMotif   = 9;
  localparam int SiteSlots  = 4;

  localparam logic [2:0] REG_MISMATCH_LIMIT = 3'd0;
  localparam logic [2:0] REG_SITE_USED      = 3'd1;
  localparam logic [2:0] REG_SITE_ZERO      = 3'd2;
  localparam logic [2:0] REG_SITE_ONE       = 3'd3;
  localparam logic [2:0] REG_SITE_TWO       = 3'd4;
  localparam logic [2:0] REG_SITE_THREE     = 3'd5;

  localparam logic [1:0] METHOD_OVERLAP = 2'd0;
  localparam logic [1:0] METHOD_CUT     = 2'd1;
  localparam logic [1:0] METHOD_JOIN    = 2'd2;

  typedef enum logic [4:0] {
    OP_IDLE, OP_LOAD, OP_OV_INIT, OP_OV_READ, OP_OV_CMP, OP_OV_NEXT, OP_OV_HIT,
    OP_FD_INIT, OP_FD_READ, OP_FD_CMP, OP_FD_HIT, OP_FD_MISS,
    OP_PR_INIT, OP_PR_NEXT, OP_PR_HIT,
    OP_OUT_INIT, OP_OUT_READ, OP_OUT_CMP, OP_OUT_EMIT
  } op_t;

  typedef enum logic [3:0] {
    S_LOAD, S_OV_INIT, S_OV_CHK, S_OV_CMP, S_FD_INIT, S_FD_CHK, S_FD_CMP,
    S_PR, S_OUT_INIT, S_OUT_CHK, S_OUT_CMP
  } state_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic ov_end;
    logic row_end;
    logic diff_ok;
    logic fd_done;
    logic fd_hit;
    logic fd_miss;
    logic pr_match;
    logic pr_last;
    logic out_flush;
    logic out_last;
  } status_t;

  function automatic logic [7:0] base_letter(input logic [1:0] code);
    logic [7:0] ch;
    case (code)
      2'd0: ch = 8'h41;
      2'd1: ch = 8'h43;
      2'd2: ch = 8'h47;
      default: ch = 8'h54;
    endcase
    return ch;
  endfunction

  function automatic logic [3:0] motif_len(input logic [3:0] raw);
    return (raw > 4'(MaxMotif)) ? 4'(MaxMotif) : raw;
  endfunction

endpackage

// ===== hw/rtl/prom_ctrl.sv =====
module prom_ctrl
  import prom_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  logic    read_end,
  input  status_t stat,
  output cmd_t    cmd,
  output logic    busy
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_LOAD;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd.op = OP_IDLE;
    busy = 1'b1;
    case (state)
      S_LOAD: begin
        busy = 1'b0;
        if (start) begin
          cmd.op = OP_LOAD;
          if (read_end) state_next = S_OV_INIT;
        end
      end
      S_OV_INIT: begin
        cmd.op = OP_OV_INIT;
        state_next = S_OV_CHK;
      end
      S_OV_CHK: begin
        if (stat.ov_end) begin
          state_next = S_FD_INIT;
        end else if (stat.row_end) begin
          if (stat.diff_ok) begin
            cmd.op = OP_OV_HIT;
            state_next = S_OUT_INIT;
          end else begin
            cmd.op = OP_OV_NEXT;
          end
        end else begin
          cmd.op = OP_OV_READ;
          state_next = S_OV_CMP;
        end
      end
      S_OV_CMP: begin
        cmd.op = OP_OV_CMP;
        state_next = S_OV_CHK;
      end
      S_FD_INIT: begin
        cmd.op = OP_FD_INIT;
        state_next = S_FD_CHK;
      end
      S_FD_CHK: begin
        if (stat.fd_done) begin
          cmd.op = OP_PR_INIT;
          state_next = S_PR;
        end else if (stat.fd_hit) begin
          cmd.op = OP_FD_HIT;
        end else if (stat.fd_miss) begin
          cmd.op = OP_FD_MISS;
        end else begin
          cmd.op = OP_FD_READ;
          state_next = S_FD_CMP;
        end
      end
      S_FD_CMP: begin
        cmd.op = OP_FD_CMP;
        state_next = S_FD_CHK;
      end
      S_PR: begin
        if (stat.pr_match) begin
          cmd.op = OP_PR_HIT;
          state_next = S_OUT_INIT;
        end else if (stat.pr_last) begin
          state_next = S_OUT_INIT;
        end else begin
          cmd.op = OP_PR_NEXT;
        end
      end
      S_OUT_INIT: begin
        cmd.op = OP_OUT_INIT;
        state_next = S_OUT_CHK;
      end
      S_OUT_CHK: begin
        if (stat.out_flush) begin
          cmd.op = OP_OUT_EMIT;
          if (stat.out_last) state_next = S_LOAD;
        end else begin
          cmd.op = OP_OUT_READ;
          state_next = S_OUT_CMP;
        end
      end
      S_OUT_CMP: begin
        cmd.op = OP_OUT_CMP;
        state_next = S_OUT_CHK;
      end
      default: state_next = S_LOAD;
    endcase
  end

endmodule

// ===== hw/rtl/prom_dp.sv =====
module prom_dp
  import prom_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output status_t     stat,
  input  logic [7:0]  base_char,
  input  logic        cfg_valid,
  input  logic [2:0]  cfg_index,
  input  logic [43:0] cfg_data,
  output logic        result_valid,
  output logic [1:0]  method,
  output logic [6:0]  first_kept,
  output logic [6:0]  second_kept,
  output logic [63:0] chunk,
  output logic [3:0]  chunk_bytes,
  output logic        chunk_last,
  output logic        truncated
);

  logic [7:0]  mem [MaxRead];
  logic [7:0]  rd_a, rd_b;
  logic [7:0]  addr_a, addr_b;

  logic [6:0]  mismatch_limit;
  logic [2:0]  site_used;
  logic [43:0] site [SiteSlots];

  logic [8:0]  len;
  logic        ovf;
  logic [6:0]  half;
  logic [7:0]  rv_base;

  logic [6:0]  off, idx, diff;
  logic [1:0]  meth;
  logic [6:0]  fk, sk;

  logic        side, fd_done;
  logic [1:0]  slot, used_m1;
  logic [6:0]  p;
  logic [3:0]  b;
  logic [3:0]  mlen;
  logic [1:0]  mcode;
  logic [6:0]  pos [2][SiteSlots];
  logic        found [2][SiteSlots];

  logic [1:0]  pi, pj;
  logic [3:0]  lf_pi;

  logic [7:0]  k, tot;
  logic [3:0]  nb;
  logic [63:0] buf_word;

  assign half = (len >= 9'(PadLen)) ? 7'((len - 9'(PadLen)) >> 1) : 7'd0;
  assign rv_base = 8'(half) + 8'(PadLen);
  assign used_m1 = (site_used == 3'd0) ? 2'd0 :
                   (site_used > 3'(SiteSlots)) ? 2'(SiteSlots - 1) : 2'(site_used - 3'd1);
  assign tot = 8'(fk) + 8'(sk);

  always_comb begin
    if (side) begin
      mlen  = motif_len(site[slot][21:18]);
      mcode = site[slot][2*b[2:0] +: 2];
    end else begin
      mlen  = motif_len(site[slot][43:40]);
      mcode = site[slot][22 + 2*b[2:0] +: 2];
    end
    if (b[3]) mcode = side ? site[slot][17:16] : site[slot][39:38];
  end

  assign lf_pi = motif_len(site[pi][43:40]);

  always_comb begin
    addr_a = 8'(off) + 8'(idx);
    addr_b = rv_base + 8'(idx);
    case (cmd.op)
      OP_FD_READ: begin
        addr_a = (side ? rv_base : 8'd0) + 8'(p) + 8'(b);
        addr_b = addr_a;
      end
      OP_OUT_READ: begin
        addr_a = (k < 8'(fk)) ? k : rv_base + (k - 8'(fk));
        addr_b = addr_a;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD && !len[8]) mem[len[7:0]] <= base_char;
    rd_a <= mem[addr_a];
    rd_b <= mem[addr_b];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mismatch_limit <= '0;
      site_used <= 3'd1;
      for (int s = 0; s < SiteSlots; s++) site[s] <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MISMATCH_LIMIT: mismatch_limit <= cfg_data[6:0];
        REG_SITE_USED:      site_used <= cfg_data[2:0];
        REG_SITE_ZERO:      site[0] <= cfg_data;
        REG_SITE_ONE:       site[1] <= cfg_data;
        REG_SITE_TWO:       site[2] <= cfg_data;
        REG_SITE_THREE:     site[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign stat.ov_end    = (8'(off) + 8'(MinOverlap)) > 8'(half);
  assign stat.row_end   = (8'(idx) + 8'(off)) == 8'(half);
  assign stat.diff_ok   = diff <= mismatch_limit;
  assign stat.fd_done   = fd_done;
  assign stat.fd_hit    = b == mlen;
  assign stat.fd_miss   = (8'(p) + 8'(mlen)) > 8'(half);
  assign stat.pr_match  = found[0][pi] && found[1][pj] &&
                          (9'(pos[0][pi]) + 9'(pos[1][pj]) + 9'(lf_pi) == 9'(half));
  assign stat.pr_last   = (pi == used_m1) && (pj == used_m1);
  assign stat.out_flush = nb[3] || (k == tot);
  assign stat.out_last  = k == tot;

  always_ff @(posedge clk) begin
    if (rst) begin
      len <= '0;
      ovf <= 1'b0;
      result_valid <= 1'b0;
      fd_done <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      case (cmd.op)
        OP_LOAD: begin
          if (len[8]) ovf <= 1'b1;
          else len <= len + 9'd1;
        end
        OP_OV_INIT: begin
          off <= '0;
          idx <= '0;
          diff <= '0;
          meth <= METHOD_JOIN;
          fk <= half;
          sk <= half;
        end
        OP_OV_CMP: begin
          if (rd_a != rd_b) diff <= diff + 7'd1;
          idx <= idx + 7'd1;
        end
        OP_OV_NEXT: begin
          off <= off + 7'd1;
          idx <= '0;
          diff <= '0;
        end
        OP_OV_HIT: begin
          meth <= METHOD_OVERLAP;
          fk <= off;
        end
        OP_FD_INIT: begin
          side <= 1'b0;
          slot <= '0;
          p <= '0;
          b <= '0;
          fd_done <= 1'b0;
        end
        OP_FD_CMP: begin
          // on a mismatch slide the motif one place and start over
          if (rd_a == base_letter(mcode)) begin
            b <= b + 4'd1;
          end else begin
            p <= p + 7'd1;
            b <= '0;
          end
        end
        OP_FD_HIT, OP_FD_MISS: begin
          found[side][slot] <= cmd.op == OP_FD_HIT;
          pos[side][slot] <= p;
          p <= '0;
          b <= '0;
          if (slot == used_m1) begin
            slot <= '0;
            if (side) fd_done <= 1'b1;
            side <= 1'b1;
          end else begin
            slot <= slot + 2'd1;
          end
        end
        OP_PR_INIT: begin
          pi <= '0;
          pj <= '0;
        end
        OP_PR_NEXT: begin
          if (pj == used_m1) begin
            pj <= '0;
            pi <= pi + 2'd1;
          end else begin
            pj <= pj + 2'd1;
          end
        end
        OP_PR_HIT: begin
          meth <= METHOD_CUT;
          fk <= pos[0][pi] + 7'(lf_pi);
          sk <= '0;
        end
        OP_OUT_INIT: begin
          k <= '0;
          nb <= '0;
          buf_word <= '0;
        end
        OP_OUT_CMP: begin
          buf_word[8*nb[2:0] +: 8] <= rd_a;
          nb <= nb + 4'd1;
          k <= k + 8'd1;
        end
        OP_OUT_EMIT: begin
          result_valid <= 1'b1;
          method <= meth;
          first_kept <= fk;
          second_kept <= sk;
          chunk <= buf_word;
          chunk_bytes <= nb;
          chunk_last <= k == tot;
          truncated <= ovf;
          nb <= '0;
          buf_word <= '0;
          if (k == tot) begin
            len <= '0;
            ovf <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== hw/rtl/paired_read_overlap_merger.sv =====
// Bytes are loaded while start is high; busy stays low while bytes stream in.
// After the final byte the overlap search compares the two halves byte by byte;
// if no overlap is found, the motif search and then the pair check run, and
// the merged read is then sent out in chunks of up to 8 bytes.
// Results appear one per strobe and the receiver cannot stall them.
// Synchronous active-high reset clears control state and configuration (site_used resets to 1).
module paired_read_overlap_merger
  import prom_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  base_char,
  input  logic        read_end,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [43:0] cfg_data,
  output logic        result_valid,
  output logic [1:0]  method,
  output logic [6:0]  first_kept,
  output logic [6:0]  second_kept,
  output logic [63:0] chunk,
  output logic [3:0]  chunk_bytes,
  output logic        chunk_last,
  output logic        truncated
);

  cmd_t    cmd;
  status_t stat;

  assign cfg_ready = 1'b1;

  prom_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .read_end(read_end),
    .stat(stat), .cmd(cmd), .busy(busy)
  );

  prom_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat), .base_char(base_char),
    .cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .result_valid(result_valid), .method(method), .first_kept(first_kept),
    .second_kept(second_kept), .chunk(chunk), .chunk_bytes(chunk_bytes),
    .chunk_last(chunk_last), .truncated(truncated)
  );

  a_method_code: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (method != 2'd3))
    else $error("bad method code");

  a_bytes_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (chunk_bytes <= 4'd8))
    else $error("chunk byte count out of range");

  a_no_result_on_load: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !read_end) |=> !result_valid)
    else $error("result during read load");

  a_more_chunks: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !chunk_last) |-> busy)
    else $error("block idle with chunks pending");

endmodule
